### rtl/core/rgbla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED animation step - shared package
// Mode and register codes, the colour type and the colour helper functions.
// ----------------------------------------------------------------------------
package rgbla_pkg;

    localparam int DUTY_W  = 8;
    localparam int COLOR_W = 24;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;
    localparam logic [DUTY_W-1:0] WHEEL_THIRD = 8'd85;
    localparam logic [DUTY_W-1:0] WHEEL_TWO_THIRDS = 8'd170;

    typedef enum logic [MODE_W-1:0] {
        MODE_RAINBOW = 3'd0,
        MODE_PARTY   = 3'd1,
        MODE_PULSE   = 3'd2,
        MODE_SOLID   = 3'd3,
        MODE_BLINK   = 3'd4
    } anim_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANIM_MODE       = 3'd0,
        REG_BASE_COLOR      = 3'd1,
        REG_DUTY_FLOOR      = 3'd2,
        REG_DUTY_CEILING    = 3'd3,
        REG_PULSE_INCREMENT = 3'd4,
        REG_RED_OFF         = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } rgb_t;

    // Three times a wheel offset; the offset is at most 85, so 8 bits hold it.
    function automatic logic [DUTY_W-1:0] triple(input logic [DUTY_W-1:0] q);
        logic [DUTY_W+1:0] t;
        t = {2'b00, q} + {1'b0, q, 1'b0};
        return t[DUTY_W-1:0];
    endfunction

    function automatic rgb_t wheel_color(input logic [DUTY_W-1:0] pos);
        rgb_t c;
        logic [DUTY_W-1:0] q3;
        c = '0;
        if (pos < WHEEL_THIRD) begin
            q3 = triple(pos);
            c.red = q3;
            c.green = DUTY_MAX - q3;
        end
        else if (pos < WHEEL_TWO_THIRDS) begin
            q3 = triple(pos - WHEEL_THIRD);
            c.red = DUTY_MAX - q3;
            c.blue = q3;
        end
        else begin
            q3 = triple(pos - WHEEL_TWO_THIRDS);
            c.green = q3;
            c.blue = DUTY_MAX - q3;
        end
        return c;
    endfunction

    // floor(c * p / 255) as (x + (x >> 8) + 1) >> 8, exact for x up to 255 * 255.
    function automatic logic [DUTY_W-1:0] scale_channel(input logic [DUTY_W-1:0] c,
                                                        input logic [DUTY_W-1:0] p);
        logic [2*DUTY_W-1:0] prod;
        logic [2*DUTY_W:0]   sum;
        prod = c * p;
        sum = {1'b0, prod} + {{(DUTY_W+1){1'b0}}, prod[2*DUTY_W-1:DUTY_W]} + 1'b1;
        return sum[2*DUTY_W-1:DUTY_W];
    endfunction

    // The floor test wins when the floor lies above the ceiling.
    function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] v,
                                                     input logic [DUTY_W-1:0] lo,
                                                     input logic [DUTY_W-1:0] hi);
        logic [DUTY_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end
        else if (v > hi) begin
            r = hi;
        end
        else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/rgb_led_animation_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED animation step unit
// One animation tick per input transaction: mode colour, clamp, change flags.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+-------------------------------------------
//  input    | in_valid / in_ready      | restart, random_value
//  output   | out_valid / out_ready    | red_duty, green_duty, blue_duty, changed_mask
//  config   | cfg_write_en (no wait)   | cfg_index, cfg_data
//
// A transaction is taken into the input register, and once the result register
// is free the tick is evaluated and written to it, so the result is offered
// from the result register, and one transaction can be taken every cycle
// while the output is not stalled. The result register can only be
// loaded once its previous transaction has been taken, and the input register
// empties only into it, so a stalled output stops the input after at most one
// more transaction. Reset clears both valid flags, the animation phase, the
// ramp direction and the stored duties, and returns the configuration
// registers to their default values.
//
// The stored duties double as the output payload: each result is exactly the
// set of duties the tick leaves behind, so no separate copy is kept.
module rgb_led_animation_step_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input transaction
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                restart,
    input  wire logic [rgbla_pkg::DUTY_W-1:0]        random_value,
    // output transaction
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [rgbla_pkg::DUTY_W-1:0]             red_duty,
    output logic [rgbla_pkg::DUTY_W-1:0]             green_duty,
    output logic [rgbla_pkg::DUTY_W-1:0]             blue_duty,
    output logic [2:0]                               changed_mask,
    // configuration writes
    input  wire logic                                cfg_write_en,
    input  wire logic [rgbla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rgbla_pkg::COLOR_W-1:0]       cfg_data
);

    localparam int DW = rgbla_pkg::DUTY_W;

    // Configuration registers
    logic [rgbla_pkg::MODE_W-1:0]  anim_mode_reg;
    logic [rgbla_pkg::COLOR_W-1:0] base_color_reg;
    logic [DW-1:0]                 duty_floor_reg;
    logic [DW-1:0]                 duty_ceiling_reg;
    logic [DW-1:0]                 pulse_increment_reg;
    logic                          red_off_reg;

    // Input register
    logic          in_valid_reg;
    logic          restart_reg;
    logic [DW-1:0] random_value_reg;

    // Animation state and result register
    logic [DW-1:0] phase_reg, phase_next;
    logic          ramp_down_reg, ramp_down_next;
    logic [DW-1:0] red_reg, green_reg, blue_reg;
    logic [2:0]    mask_reg, mask_next;
    logic          out_valid_reg;

    rgbla_pkg::rgb_t color, duty, base;
    logic            drive;
    logic [DW-1:0]   phase_start;
    logic            ramp_start;
    logic            out_free;
    logic            advance;

    // The result register is free when empty or being emptied this cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_mode_reg       <= rgbla_pkg::MODE_RAINBOW;
            base_color_reg      <= {rgbla_pkg::COLOR_W{1'b1}};
            duty_floor_reg      <= '0;
            duty_ceiling_reg    <= rgbla_pkg::DUTY_MAX;
            pulse_increment_reg <= 8'd5;
            red_off_reg         <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                rgbla_pkg::REG_ANIM_MODE:
                    anim_mode_reg <= cfg_data[rgbla_pkg::MODE_W-1:0];
                rgbla_pkg::REG_BASE_COLOR:
                    base_color_reg <= cfg_data;
                rgbla_pkg::REG_DUTY_FLOOR:
                    duty_floor_reg <= cfg_data[DW-1:0];
                rgbla_pkg::REG_DUTY_CEILING:
                    duty_ceiling_reg <= cfg_data[DW-1:0];
                rgbla_pkg::REG_PULSE_INCREMENT:
                    pulse_increment_reg <= cfg_data[DW-1:0];
                rgbla_pkg::REG_RED_OFF:
                    red_off_reg <= cfg_data[0];
                default:
                    ; // writes beyond the register list are ignored
            endcase
        end
    end

    // Input register: holds one tick until the result register can take it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            restart_reg      <= restart;
            random_value_reg <= random_value;
        end
    end

    // Tick evaluation. A restart clears the phase and turns the ramp up first.
    always_comb
    begin
        phase_start    = restart_reg ? '0 : phase_reg;
        ramp_start     = restart_reg ? 1'b0 : ramp_down_reg;
        phase_next     = phase_start;
        ramp_down_next = ramp_start;
        base           = base_color_reg;
        color          = '0;
        drive          = 1'b1;

        case (anim_mode_reg)
            rgbla_pkg::MODE_RAINBOW:
            begin
                color      = rgbla_pkg::wheel_color(phase_start);
                phase_next = phase_start + 1'b1;
            end
            rgbla_pkg::MODE_PARTY:
            begin
                color = rgbla_pkg::wheel_color(random_value_reg);
            end
            rgbla_pkg::MODE_PULSE:
            begin
                // Move the phase first, saturating at either end of the range and turning there.
                if (!ramp_start)
                begin
                    if (phase_start <= rgbla_pkg::DUTY_MAX - pulse_increment_reg)
                    begin
                        phase_next = phase_start + pulse_increment_reg;
                    end
                    else
                    begin
                        phase_next     = rgbla_pkg::DUTY_MAX;
                        ramp_down_next = 1'b1;
                    end
                end
                else
                begin
                    if (phase_start >= pulse_increment_reg)
                    begin
                        phase_next = phase_start - pulse_increment_reg;
                    end
                    else
                    begin
                        phase_next     = '0;
                        ramp_down_next = 1'b0;
                    end
                end
                color.red   = rgbla_pkg::scale_channel(base.red, phase_next);
                color.green = rgbla_pkg::scale_channel(base.green, phase_next);
                color.blue  = rgbla_pkg::scale_channel(base.blue, phase_next);
            end
            rgbla_pkg::MODE_SOLID:
            begin
                color = base;
            end
            rgbla_pkg::MODE_BLINK:
            begin
                // Colour on the up half, black on the down half.
                if (!ramp_start)
                begin
                    color = base;
                end
                ramp_down_next = !ramp_start;
            end
            default:
            begin
                // Undefined modes drive nothing and keep the previous duties.
                drive = 1'b0;
            end
        endcase

        duty.red   = rgbla_pkg::clamp_duty(color.red, duty_floor_reg, duty_ceiling_reg);
        duty.green = rgbla_pkg::clamp_duty(color.green, duty_floor_reg, duty_ceiling_reg);
        duty.blue  = rgbla_pkg::clamp_duty(color.blue, duty_floor_reg, duty_ceiling_reg);

        mask_next = '0;
        if (drive)
        begin
            mask_next[0] = (duty.red != red_reg) && !red_off_reg;
            mask_next[1] = duty.green != green_reg;
            mask_next[2] = duty.blue != blue_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            ramp_down_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            mask_reg      <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                phase_reg     <= phase_next;
                ramp_down_reg <= ramp_down_next;
                mask_reg      <= mask_next;
                if (drive)
                begin
                    red_reg   <= duty.red;
                    green_reg <= duty.green;
                    blue_reg  <= duty.blue;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_duty     = red_reg;
    assign green_duty   = green_reg;
    assign blue_duty    = blue_reg;
    assign changed_mask = mask_reg;

endmodule
`default_nettype wire

### rtl/core/rgbla_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED animation step - port checker
// Watches the output channel of the step unit; bound into the step unit module.
// ----------------------------------------------------------------------------
module rgbla_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [rgbla_pkg::DUTY_W-1:0] red_duty,
    input wire logic [rgbla_pkg::DUTY_W-1:0] green_duty,
    input wire logic [rgbla_pkg::DUTY_W-1:0] blue_duty,
    input wire logic [2:0]                   changed_mask
);

    logic out_take;
    assign out_take = out_valid && out_ready;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_duty) && $stable(green_duty)
            && $stable(blue_duty) && $stable(changed_mask))
    else $error("output transaction changed while stalled");

    // On consecutive results the green flag marks exactly a change of green duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take ##1 out_take |-> changed_mask[1] == (green_duty != $past(green_duty)))
    else $error("green change flag disagrees with the duty sequence");

    // The same for blue.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take ##1 out_take |-> changed_mask[2] == (blue_duty != $past(blue_duty)))
    else $error("blue change flag disagrees with the duty sequence");

    // A result with no flag set leaves green and blue unchanged from the one before.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take ##1 (out_take && changed_mask == 3'b000) |->
            $stable(green_duty) && $stable(blue_duty))
    else $error("duties changed without a change flag");

endmodule

bind rgb_led_animation_step_unit rgbla_checker u_rgbla_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red_duty     (red_duty),
    .green_duty   (green_duty),
    .blue_duty    (blue_duty),
    .changed_mask (changed_mask)
);
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB LED animation step unit - self-checking testbench
// Drives animation ticks through the valid/ready input channel and checks
// every duty transaction against an independent model of the colour
// engine, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    // The run is ended as a failure if it goes on for longer than this.
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles for which the output side holds off in the long stall.
    localparam int LONG_HOLD     = 60;
    // Cycles allowed after the last result before the final verdict.
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_PHASES = 14;

    // One animation tick as offered on the input channel.
    typedef struct {
        logic                         restart;
        logic [rgbla_pkg::DUTY_W-1:0] random_value;
    } tick_t;

    // One set of duties as returned on the output channel.
    typedef struct {
        logic [rgbla_pkg::DUTY_W-1:0] red;
        logic [rgbla_pkg::DUTY_W-1:0] green;
        logic [rgbla_pkg::DUTY_W-1:0] blue;
        logic [2:0]                   mask;
    } duty_set_t;

    // Every input of the block starts from a known value.
    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            in_valid     = 1'b0;
    logic                            restart      = 1'b0;
    logic [rgbla_pkg::DUTY_W-1:0]    random_value = '0;
    logic                            out_ready    = 1'b0;
    logic                            cfg_write_en = 1'b0;
    logic [rgbla_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [rgbla_pkg::COLOR_W-1:0]   cfg_data     = '0;

    logic                            in_ready;
    logic                            out_valid;
    logic [rgbla_pkg::DUTY_W-1:0]    red_duty;
    logic [rgbla_pkg::DUTY_W-1:0]    green_duty;
    logic [rgbla_pkg::DUTY_W-1:0]    blue_duty;
    logic [2:0]                      changed_mask;

    rgb_led_animation_step_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_duty     (red_duty),
        .green_duty   (green_duty),
        .blue_duty    (blue_duty),
        .changed_mask (changed_mask),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model of the animation engine: its own copy of the registers and state.
    // ------------------------------------------------------------------------
    logic [rgbla_pkg::MODE_W-1:0]  mode_setting    = rgbla_pkg::MODE_RAINBOW;
    logic [rgbla_pkg::COLOR_W-1:0] colour_setting  = 24'hFFFFFF;
    logic [rgbla_pkg::DUTY_W-1:0]  floor_setting   = 8'd0;
    logic [rgbla_pkg::DUTY_W-1:0]  ceiling_setting = 8'd255;
    logic [rgbla_pkg::DUTY_W-1:0]  step_setting    = 8'd5;
    logic                          red_masked      = 1'b0;

    logic [rgbla_pkg::DUTY_W-1:0]  anim_phase   = '0;
    logic                          ramp_falling = 1'b0;
    logic [rgbla_pkg::DUTY_W-1:0]  held_duty [3] = '{8'd0, 8'd0, 8'd0};

    tick_t     tick_backlog [$];
    duty_set_t pending_duties [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  idling_on   = 1'b1;
    bit  hold_request = 1'b0;
    bit  in_taken    = 1'b0;
    int  gap_left    = 0;
    int  stall_left  = 0;
    int  hold_left   = 0;
    // Ticks queued but not yet accepted by the block.
    int  ticks_outstanding = 0;

    // Colour wheel: three ramps of 85, 85 and 86 positions, each a cross-fade between
    // two primaries.
    function automatic rgbla_pkg::rgb_t colour_wheel_lookup(
        input logic [rgbla_pkg::DUTY_W-1:0] pos);
        rgbla_pkg::rgb_t c;
        int   p;
        c = '0;
        p = int'(pos);
        if (p < 85)
        begin
            c.red   = 8'(3 * p);
            c.green = 8'(255 - 3 * p);
        end
        else if (p < 170)
        begin
            c.red  = 8'(255 - 3 * (p - 85));
            c.blue = 8'(3 * (p - 85));
        end
        else
        begin
            c.green = 8'(3 * (p - 170));
            c.blue  = 8'(255 - 3 * (p - 170));
        end
        return c;
    endfunction

    // The floor is tested first, so it wins when it lies above the ceiling.
    function automatic logic [rgbla_pkg::DUTY_W-1:0] bound_duty(
        input logic [rgbla_pkg::DUTY_W-1:0] v);
        if (v < floor_setting)
            return floor_setting;
        if (v > ceiling_setting)
            return ceiling_setting;
        return v;
    endfunction

    // Advances the model by one tick and queues the duties it leaves behind.
    task automatic advance_animation(input logic rs,
                                     input logic [rgbla_pkg::DUTY_W-1:0] rv);
        rgbla_pkg::rgb_t              colour;
        logic [rgbla_pkg::DUTY_W-1:0] comp [3];
        logic [rgbla_pkg::DUTY_W-1:0] duty;
        logic                         drive;
        logic [2:0]                   mask;
        duty_set_t                    result;
        colour = '0;
        drive  = 1'b1;
        mask   = '0;
        if (rs)
        begin
            anim_phase   = '0;
            ramp_falling = 1'b0;
        end
        case (mode_setting)
            rgbla_pkg::MODE_RAINBOW:
            begin
                colour     = colour_wheel_lookup(anim_phase);
                anim_phase = anim_phase + 8'd1;
            end
            rgbla_pkg::MODE_PARTY:
                colour = colour_wheel_lookup(rv);
            rgbla_pkg::MODE_PULSE:
            begin
                // The ramp saturates at either end and turns round there.
                if (!ramp_falling)
                begin
                    if (anim_phase <= rgbla_pkg::DUTY_MAX - step_setting)
                        anim_phase = anim_phase + step_setting;
                    else
                    begin
                        anim_phase   = rgbla_pkg::DUTY_MAX;
                        ramp_falling = 1'b1;
                    end
                end
                else
                begin
                    if (anim_phase >= step_setting)
                        anim_phase = anim_phase - step_setting;
                    else
                    begin
                        anim_phase   = '0;
                        ramp_falling = 1'b0;
                    end
                end
                colour.red   = 8'((int'(colour_setting[23:16]) * int'(anim_phase)) / 255);
                colour.green = 8'((int'(colour_setting[15:8]) * int'(anim_phase)) / 255);
                colour.blue  = 8'((int'(colour_setting[7:0]) * int'(anim_phase)) / 255);
            end
            rgbla_pkg::MODE_SOLID:
                colour = colour_setting;
            rgbla_pkg::MODE_BLINK:
            begin
                if (!ramp_falling)
                    colour = colour_setting;
                ramp_falling = ~ramp_falling;
            end
            default:
                drive = 1'b0;
        endcase
        if (drive)
        begin
            comp[0] = colour.red;
            comp[1] = colour.green;
            comp[2] = colour.blue;
            for (int i = 0; i < 3; i++)
            begin
                duty = bound_duty(comp[i]);
                if (duty != held_duty[i] && !(i == 0 && red_masked))
                    mask[i] = 1'b1;
                held_duty[i] = duty;
            end
        end
        result.red   = held_duty[0];
        result.green = held_duty[1];
        result.blue  = held_duty[2];
        result.mask  = mask;
        pending_duties.push_back(result);
    endtask

    // ------------------------------------------------------------------------
    // Input side: the driver offers backlog items at the falling edge, and
    // each accepted transaction is fed to the model at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken = ((in_valid && in_ready) === 1'b1) && rst_n;
        if (in_taken)
        begin
            ticks_outstanding--;
            advance_animation(restart, random_value);
        end
    end

    always @(negedge clk)
    begin : drive_ticks
        tick_t next_tick;
        if (in_valid && !in_taken)
        begin
            // Still waiting for acceptance: the payload is held as it is.
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (rst_n && tick_backlog.size() > 0)
        begin
            next_tick = tick_backlog.pop_front();
            restart      <= next_tick.restart;
            random_value <= next_tick.random_value;
            in_valid     <= 1'b1;
            // Now and then a burst of idle cycles follows this transaction.
            if (idling_on && $urandom_range(0, 5) == 0)
                gap_left = $urandom_range(1, 9);
        end
        else
            in_valid <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Output side: random stall bursts, plus one long hold-off on request so
    // that the block fills up and has to stop its input.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            out_ready   <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (rst_n && idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    function automatic void check_field(input string name, input int expected_value,
                                        input int actual_value);
        if (expected_value != actual_value)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected_value, actual_value);
            error_count++;
        end
    endfunction

    // Each result transaction is compared with the oldest predicted duty set.
    always @(posedge clk)
    begin : compare_duties
        duty_set_t want;
        if (rst_n && (out_valid && out_ready) === 1'b1)
        begin
            if (pending_duties.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d mask %0d",
                         $time, red_duty, green_duty, blue_duty, changed_mask);
                error_count++;
            end
            else
            begin
                want = pending_duties.pop_front();
                check_field("red_duty", want.red, red_duty);
                check_field("green_duty", want.green, green_duty);
                check_field("blue_duty", want.blue, blue_duty);
                check_field("changed_mask", want.mask, changed_mask);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers.
    // ------------------------------------------------------------------------
    task automatic queue_tick(input logic rs, input logic [rgbla_pkg::DUTY_W-1:0] rv);
        tick_t t;
        t.restart      = rs;
        t.random_value = rv;
        ticks_outstanding++;
        tick_backlog.push_back(t);
    endtask

    // Waits until every queued tick has been accepted and every result has
    // come back, then lets the pipeline settle.
    task automatic wait_for_quiet();
        @(negedge clk);
        while (ticks_outstanding != 0 || pending_duties.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Drives one register write; the model takes the same masked value.
    task automatic write_register(input logic [rgbla_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rgbla_pkg::COLOR_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        case (idx)
            rgbla_pkg::REG_ANIM_MODE:       mode_setting    = data[rgbla_pkg::MODE_W-1:0];
            rgbla_pkg::REG_BASE_COLOR:      colour_setting  = data;
            rgbla_pkg::REG_DUTY_FLOOR:      floor_setting   = data[rgbla_pkg::DUTY_W-1:0];
            rgbla_pkg::REG_DUTY_CEILING:    ceiling_setting = data[rgbla_pkg::DUTY_W-1:0];
            rgbla_pkg::REG_PULSE_INCREMENT: step_setting    = data[rgbla_pkg::DUTY_W-1:0];
            rgbla_pkg::REG_RED_OFF:         red_masked      = data[0];
            default:                        ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Picks a setting for one random phase. Upper data bits beyond a
    // register's width are filled with noise, since the block must drop them.
    task automatic configure_phase(input int phase_no);
        logic [rgbla_pkg::MODE_W-1:0]  mode_val;
        logic [rgbla_pkg::COLOR_W-1:0] colour_val;
        logic [rgbla_pkg::DUTY_W-1:0]  lo;
        logic [rgbla_pkg::DUTY_W-1:0]  hi;
        logic [rgbla_pkg::DUTY_W-1:0]  step;
        if (phase_no % 7 == 6)
            mode_val = 3'($urandom_range(5, 7));
        else
            mode_val = 3'(phase_no % 5);
        case (phase_no % 4)
            0:       colour_val = 24'hFFFFFF;
            1:       colour_val = 24'h000000;
            default: colour_val = 24'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:
            begin
                lo = 8'd255;
                hi = 8'd0;
            end
            1:
            begin
                lo = 8'($urandom_range(100, 255));
                hi = 8'($urandom_range(0, 99));
            end
            2:
            begin
                lo = 8'($urandom_range(0, 60));
                hi = 8'($urandom_range(180, 255));
            end
            default:
            begin
                lo = 8'd0;
                hi = 8'd255;
            end
        endcase
        case ($urandom_range(0, 5))
            0:       step = 8'd1;
            1:       step = 8'd255;
            2:       step = 8'd0;
            default: step = 8'($urandom_range(1, 255));
        endcase
        write_register(rgbla_pkg::REG_ANIM_MODE, {21'($urandom), mode_val});
        write_register(rgbla_pkg::REG_BASE_COLOR, colour_val);
        write_register(rgbla_pkg::REG_DUTY_FLOOR, {16'($urandom), lo});
        write_register(rgbla_pkg::REG_DUTY_CEILING, {16'($urandom), hi});
        write_register(rgbla_pkg::REG_PULSE_INCREMENT, {16'($urandom), step});
        write_register(rgbla_pkg::REG_RED_OFF, {23'($urandom), 1'($urandom)});
        end_writes();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: a directed opening, then random phases with a fresh setting
    // each. Every phase ends with the sender paused until all results are in.
    // ------------------------------------------------------------------------
    initial
    begin : run_sequence
        int count;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting, rainbow from phase zero, with a restart in between.
        queue_tick(1'b0, 8'h00);
        queue_tick(1'b1, 8'hFF);
        queue_tick(1'b0, 8'h80);
        wait_for_quiet();

        // Party mode at each segment boundary of the wheel, and position 255.
        write_register(rgbla_pkg::REG_ANIM_MODE, 24'(rgbla_pkg::MODE_PARTY));
        write_register(rgbla_pkg::REG_BASE_COLOR, 24'hFFFFFF);
        write_register(rgbla_pkg::REG_DUTY_FLOOR, 24'd0);
        write_register(rgbla_pkg::REG_DUTY_CEILING, 24'd255);
        write_register(rgbla_pkg::REG_PULSE_INCREMENT, 24'd255);
        write_register(rgbla_pkg::REG_RED_OFF, 24'd0);
        // An index past the last register must be ignored.
        write_register(3'(rgbla_pkg::REG_RED_OFF) + 3'd1, 24'hFFFFFF);
        end_writes();
        queue_tick(1'b0, 8'd0);
        queue_tick(1'b0, 8'd84);
        queue_tick(1'b0, 8'd85);
        queue_tick(1'b0, 8'd169);
        queue_tick(1'b0, 8'd170);
        queue_tick(1'b0, 8'd254);
        queue_tick(1'b0, 8'd255);
        wait_for_quiet();

        // Pulse with the largest step: saturates at the top, then the bottom.
        write_register(rgbla_pkg::REG_ANIM_MODE, 24'(rgbla_pkg::MODE_PULSE));
        end_writes();
        queue_tick(1'b1, 8'd0);
        queue_tick(1'b0, 8'd0);
        queue_tick(1'b0, 8'd0);
        queue_tick(1'b0, 8'd0);
        wait_for_quiet();

        // A zero step leaves the phase where it is.
        write_register(rgbla_pkg::REG_PULSE_INCREMENT, 24'd0);
        end_writes();
        queue_tick(1'b0, 8'd0);
        queue_tick(1'b0, 8'd0);
        wait_for_quiet();

        // Solid colour with the floor above the ceiling and red disabled.
        write_register(rgbla_pkg::REG_ANIM_MODE, 24'(rgbla_pkg::MODE_SOLID));
        write_register(rgbla_pkg::REG_BASE_COLOR, 24'h000000);
        write_register(rgbla_pkg::REG_DUTY_FLOOR, 24'd200);
        write_register(rgbla_pkg::REG_DUTY_CEILING, 24'd50);
        write_register(rgbla_pkg::REG_RED_OFF, 24'd1);
        end_writes();
        queue_tick(1'b0, 8'd0);
        wait_for_quiet();
        write_register(rgbla_pkg::REG_BASE_COLOR, 24'hFFFFFF);
        end_writes();
        queue_tick(1'b0, 8'd0);
        wait_for_quiet();

        // Blink alternates the colour with black.
        write_register(rgbla_pkg::REG_ANIM_MODE, 24'(rgbla_pkg::MODE_BLINK));
        write_register(rgbla_pkg::REG_BASE_COLOR, 24'h123456);
        write_register(rgbla_pkg::REG_DUTY_FLOOR, 24'd0);
        write_register(rgbla_pkg::REG_DUTY_CEILING, 24'd255);
        write_register(rgbla_pkg::REG_RED_OFF, 24'd0);
        end_writes();
        queue_tick(1'b0, 8'd0);
        queue_tick(1'b0, 8'd0);
        queue_tick(1'b0, 8'd0);
        wait_for_quiet();

        // An undefined mode drives nothing; the restart still applies.
        write_register(rgbla_pkg::REG_ANIM_MODE, 24'hFFFFFF);
        end_writes();
        queue_tick(1'b1, 8'd0);
        queue_tick(1'b0, 8'd3);
        wait_for_quiet();

        for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            // The last stretch of the run has no idling at all.
            if (phase_no >= RANDOM_PHASES - 3)
                idling_on = 1'b0;
            configure_phase(phase_no);
            // The first rainbow phase runs long enough for the phase to wrap.
            count = (phase_no == 0) ? 300 : 40;
            for (int i = 0; i < count; i++)
                queue_tick(phase_no != 0 && $urandom_range(0, 39) == 0,
                           8'($urandom_range(0, 255)));
            // Long receiver hold-off while the backlog is still being offered.
            if (phase_no == 2)
                hold_request = 1'b1;
            wait_for_quiet();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/rgbla_pkg.sv
rtl/core/rgb_led_animation_step_unit.sv
rtl/core/rgbla_checker.sv
bench/testbench.sv
